// File: hw/rtl/key_matrix_change_detector_macros.svh
// Assertion macros for the key matrix change detector.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef KEY_MATRIX_CHANGE_DETECTOR_MACROS_SVH
`define KEY_MATRIX_CHANGE_DETECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KMCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KMCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/kmcd_pkg.sv
// Shared types and constants of the key matrix change detector.
// No dependencies; every module and interface of the block imports it.
`default_nettype none

package kmcd_pkg;

  localparam int TIME_W      = 32;
  localparam int LEVELS_W    = 64;
  localparam int KEY_NUM_W   = 7;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int DIGIT_W     = 4;
  localparam int DIGITS      = TIME_W / DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(DIGITS);

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_DELAY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT      = CFG_IDX_W'(1);

  localparam logic [TIME_W-1:0]    DEBOUNCE_RESET  = TIME_W'(15000);
  localparam logic [KEY_NUM_W-1:0] KEY_COUNT_RESET = KEY_NUM_W'(64);

  // Result of the debounce lockout check.
  typedef struct packed {
    logic done;
    logic locked;
  } lock_res_t;

  // Commands to the scan datapath.
  typedef struct packed {
    logic load;
    logic step;
  } scan_ctrl_t;

  // What the scan datapath sees at the key under test.
  typedef struct packed {
    logic                 changed;
    logic                 level;
    logic [KEY_NUM_W-1:0] key_number;
    logic                 at_end;
  } scan_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/kmcd_if.sv
// Valid/ready channel interfaces: configuration writes, polls and key events.
// Depends on kmcd_pkg for the payload widths.
`default_nettype none

interface kmcd_cfg_if import kmcd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface kmcd_in_if import kmcd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   now_us;
  logic [LEVELS_W-1:0] key_levels;

  modport source (output valid, now_us, key_levels, input ready);
  modport sink   (input valid, now_us, key_levels, output ready);
endinterface

interface kmcd_out_if import kmcd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KEY_NUM_W-1:0] key_number;
  logic                 pressed;
  logic                 last;

  modport source (output valid, key_number, pressed, last, input ready);
  modport sink   (input valid, key_number, pressed, last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/kmcd_lockout.sv
// Debounce lockout: digit-serial elapsed-time subtract and compare, and the
// last change time register. Depends on kmcd_pkg.
`default_nettype none

module kmcd_lockout import kmcd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [TIME_W-1:0] now_us_i,
  input  wire logic [TIME_W-1:0] delay_i,
  input  wire logic              commit_i,
  output lock_res_t              res_o
);

  localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = DIGIT_CNT_W'(DIGITS - 1);

  logic                   busy_q;
  logic [DIGIT_CNT_W-1:0] cnt_q;
  logic                   borrow_q;
  logic                   lt_q;
  logic                   done_q;
  logic                   locked_q;
  logic [TIME_W-1:0]      now_q;
  logic [TIME_W-1:0]      last_sh_q;
  logic [TIME_W-1:0]      dly_sh_q;
  logic [TIME_W-1:0]      last_chg_q;

  logic [DIGIT_W:0]   diff;
  logic [DIGIT_W-1:0] e_dig;
  logic [DIGIT_W-1:0] d_dig;
  logic               lt_d;

  // One digit of (now - last) per cycle, least significant first. The running
  // compare is decided by the most significant digit that differs.
  always_comb begin
    diff  = {1'b0, now_q[DIGIT_W-1:0]} - {1'b0, last_sh_q[DIGIT_W-1:0]}
            - (DIGIT_W+1)'(borrow_q);
    e_dig = diff[DIGIT_W-1:0];
    d_dig = dly_sh_q[DIGIT_W-1:0];
    if (e_dig < d_dig) begin
      lt_d = 1'b1;
    end else if (e_dig > d_dig) begin
      lt_d = 1'b0;
    end else begin
      lt_d = lt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      cnt_q      <= '0;
      borrow_q   <= 1'b0;
      lt_q       <= 1'b0;
      done_q     <= 1'b0;
      locked_q   <= 1'b0;
      last_chg_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q   <= 1'b1;
        cnt_q    <= '0;
        borrow_q <= 1'b0;
        lt_q     <= 1'b0;
      end else if (busy_q) begin
        cnt_q    <= cnt_q + DIGIT_CNT_W'(1);
        borrow_q <= diff[DIGIT_W];
        lt_q     <= lt_d;
        if (cnt_q == LAST_DIGIT) begin
          busy_q   <= 1'b0;
          done_q   <= 1'b1;
          locked_q <= lt_d;
        end
      end
      if (commit_i) begin
        last_chg_q <= now_q;
      end
    end
  end

  // Operand shift registers. The timestamp rotates, so it is whole again once
  // every digit has been used and can be committed as the new change time.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      now_q     <= now_us_i;
      last_sh_q <= last_chg_q;
      dly_sh_q  <= delay_i;
    end else if (busy_q) begin
      now_q     <= {now_q[DIGIT_W-1:0], now_q[TIME_W-1:DIGIT_W]};
      last_sh_q <= last_sh_q >> DIGIT_W;
      dly_sh_q  <= dly_sh_q >> DIGIT_W;
    end
  end

  assign res_o.done   = done_q;
  assign res_o.locked = locked_q;

endmodule

`default_nettype wire

// File: hw/rtl/kmcd_scan.sv
// Key scan datapath: the stored key levels and the polled levels as shift
// registers, tested one key per cycle at bit 0 unless the scan is held. Depends on kmcd_pkg.
`default_nettype none

module kmcd_scan import kmcd_pkg::*; #(
  parameter int MAX_KEYS = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire scan_ctrl_t           ctrl_i,
  input  wire logic [MAX_KEYS-1:0]  levels_i,
  input  wire logic [KEY_NUM_W-1:0] key_used_i,
  output scan_stat_t                stat_o
);

  localparam logic [KEY_NUM_W-1:0] LAST_IDX = KEY_NUM_W'(MAX_KEYS - 1);

  logic [MAX_KEYS-1:0]  store_q;
  logic [MAX_KEYS-1:0]  store_d;
  logic [MAX_KEYS-1:0]  lvl_q;
  logic [KEY_NUM_W-1:0] idx_q;
  logic                 changed;

  assign changed = (lvl_q[0] != store_q[0]) && (idx_q < key_used_i);

  // The store rotates once per scan step; after a full scan every key is back
  // in its own place, carrying the polled level where it changed.
  always_comb begin
    store_d               = store_q >> 1;
    store_d[MAX_KEYS-1]   = changed ? lvl_q[0] : store_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '1;
      idx_q   <= '0;
    end else begin
      if (ctrl_i.load) begin
        idx_q <= '0;
      end else if (ctrl_i.step) begin
        idx_q   <= idx_q + KEY_NUM_W'(1);
        store_q <= store_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      lvl_q <= levels_i;
    end else if (ctrl_i.step) begin
      lvl_q <= lvl_q >> 1;
    end
  end

  assign stat_o.changed    = changed;
  assign stat_o.level      = lvl_q[0];
  assign stat_o.key_number = idx_q + KEY_NUM_W'(1);
  assign stat_o.at_end     = (idx_q == LAST_IDX);

endmodule

`default_nettype wire

// File: hw/rtl/key_matrix_change_detector.sv
// Key matrix change detector, top level: control sequencer, configuration
// registers and the event output register. Depends on kmcd_pkg, kmcd_if,
// kmcd_lockout, kmcd_scan and key_matrix_change_detector_macros.svh.
//
// Usage. A poll beat on poll_i carries a wrapping microsecond timestamp and
// the level of every key. The block takes one poll at a time. It first checks
// the debounce lockout, one 4-bit digit of the elapsed time per cycle; a poll
// inside the lockout produces no events. Otherwise the scan shift registers
// step through all MAX_KEYS key positions one per cycle while the receiver
// keeps up, testing the keys in use. Each key that changed yields one event
// beat on event_o (one-based key number, pressed flag), in key order, the
// final one of the poll with last set. A single output register parts the
// scan from the receiver; if the receiver stalls, the scan waits at the next
// changed key until the beat is taken. Configuration beats on cfg_i are
// always taken and belong only in idle periods; index 0 is the debounce delay,
// index 1 the key count, others are ignored. Reset restores 15000 us and 64
// keys, marks every key released and sets the last change time to zero; there
// is no clearing pass.
`default_nettype none
`include "key_matrix_change_detector_macros.svh"

module key_matrix_change_detector import kmcd_pkg::*; #(
  parameter int MAX_KEYS = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  kmcd_cfg_if.sink    cfg_i,
  kmcd_in_if.sink     poll_i,
  kmcd_out_if.source  event_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOCK,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  localparam logic [KEY_NUM_W-1:0] MAX_KEYS_W = KEY_NUM_W'(MAX_KEYS);

  // Configuration registers.
  logic [TIME_W-1:0]    delay_q;
  logic [KEY_NUM_W-1:0] key_count_q;
  logic [KEY_NUM_W-1:0] key_used;

  // Sequencer, held event and output register.
  state_e               state_q, state_d;
  logic                 pend_q, pend_d;
  logic [KEY_NUM_W-1:0] pend_num_q, pend_num_d;
  logic                 pend_prs_q, pend_prs_d;
  logic                 ovalid_q, ovalid_d;
  logic [KEY_NUM_W-1:0] onum_q, onum_d;
  logic                 oprs_q, oprs_d;
  logic                 olast_q, olast_d;

  logic       poll_acc;
  logic       out_take;
  logic       commit;
  lock_res_t  lock_res;
  scan_ctrl_t scan_ctrl;
  scan_stat_t scan_stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= DEBOUNCE_RESET;
      key_count_q <= KEY_COUNT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DEBOUNCE_DELAY: delay_q     <= cfg_i.data;
        REG_KEY_COUNT:      key_count_q <= cfg_i.data[KEY_NUM_W-1:0];
        default:            ;
      endcase
    end
  end

  // Key counts above the build size saturate.
  assign key_used = (key_count_q > MAX_KEYS_W) ? MAX_KEYS_W : key_count_q;

  assign poll_i.ready = (state_q == ST_IDLE);
  assign poll_acc     = poll_i.valid && poll_i.ready;
  // The output register can take a beat when empty or being emptied.
  assign out_take     = !ovalid_q || event_o.ready;

  kmcd_lockout u_lockout (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (poll_acc),
    .now_us_i (poll_i.now_us),
    .delay_i  (delay_q),
    .commit_i (commit),
    .res_o    (lock_res)
  );

  kmcd_scan #(
    .MAX_KEYS (MAX_KEYS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .levels_i   (poll_i.key_levels[MAX_KEYS-1:0]),
    .key_used_i (key_used),
    .stat_o     (scan_stat)
  );

  // A changed key is held back until the next one or the end of the scan, so
  // that the final event of a poll can be flagged once no further key changed.
  always_comb begin
    state_d        = state_q;
    pend_d         = pend_q;
    pend_num_d     = pend_num_q;
    pend_prs_d     = pend_prs_q;
    ovalid_d       = ovalid_q && !event_o.ready;
    onum_d         = onum_q;
    oprs_d         = oprs_q;
    olast_d        = olast_q;
    commit         = 1'b0;
    scan_ctrl.load = poll_acc;
    scan_ctrl.step = 1'b0;

    case (state_q)
      ST_IDLE: begin
        pend_d = 1'b0;
        if (poll_acc) begin
          state_d = ST_LOCK;
        end
      end
      ST_LOCK: begin
        if (lock_res.done) begin
          state_d = lock_res.locked ? ST_IDLE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!(scan_stat.changed && pend_q && !out_take)) begin
          scan_ctrl.step = 1'b1;
          if (scan_stat.changed) begin
            if (pend_q) begin
              ovalid_d = 1'b1;
              onum_d   = pend_num_q;
              oprs_d   = pend_prs_q;
              olast_d  = 1'b0;
            end
            pend_d     = 1'b1;
            pend_num_d = scan_stat.key_number;
            pend_prs_d = !scan_stat.level;
          end
          if (scan_stat.at_end) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_q) begin
          state_d = ST_IDLE;
        end else if (out_take) begin
          ovalid_d = 1'b1;
          onum_d   = pend_num_q;
          oprs_d   = pend_prs_q;
          olast_d  = 1'b1;
          pend_d   = 1'b0;
          commit   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_q     <= 1'b0;
      ovalid_q   <= 1'b0;
      pend_num_q <= '0;
      pend_prs_q <= 1'b0;
      onum_q     <= '0;
      oprs_q     <= 1'b0;
      olast_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_q     <= pend_d;
      ovalid_q   <= ovalid_d;
      pend_num_q <= pend_num_d;
      pend_prs_q <= pend_prs_d;
      onum_q     <= onum_d;
      oprs_q     <= oprs_d;
      olast_q    <= olast_d;
    end
  end

  assign event_o.valid      = ovalid_q;
  assign event_o.key_number = onum_q;
  assign event_o.pressed    = oprs_q;
  assign event_o.last       = olast_q;

  // The lockout result may only arrive while the sequencer waits for it.
  `KMCD_ASSERT_IMP(a_lock_done_in_lock, lock_res.done, state_q == ST_LOCK, "lockout result outside lock wait")
  // Once the final event of a poll is handed over, nothing stays held back.
  `KMCD_ASSERT_NXT(a_flush_empties, state_q == ST_FLUSH && out_take, state_q == ST_IDLE && !pend_q, "flush left a held event")
  // Every event names a key that exists.
  `KMCD_ASSERT_IMP(a_key_in_range, event_o.valid, event_o.key_number != '0 && event_o.key_number <= MAX_KEYS_W, "event key number out of range")

endmodule

`default_nettype wire
